// ===== hw/rtl/antialiased_circle_rasterizer_core_macros.svh =====
// Assertion macros for the antialiased circle rasterizer core.
// No dependencies; included by the top level, which carries the concurrent checks.
`ifndef ANTIALIASED_CIRCLE_RASTERIZER_CORE_MACROS_SVH
`define ANTIALIASED_CIRCLE_RASTERIZER_CORE_MACROS_SVH

`ifndef SYNTH
// Check an implication or a plain property on the rising clock edge
`define ACR_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("acr assertion failed");
// Check that an expression is never true on the rising clock edge
`define ACR_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("acr forbidden condition seen");
`else
`define ACR_ASSERT(lbl, clk, rst, prop)
`define ACR_ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

// ===== hw/rtl/acr_pkg.sv =====
// Shared types and constants of the antialiased circle rasterizer core.
// No dependencies; imported by the controller, datapath and top level.
package acr_pkg;

   // Default coordinate width and fixed field widths
   localparam int COORD_BITS_DEF = 12;
   localparam int FIELD_BITS     = 12;
   localparam int PIX_BITS       = 15;
   localparam int DEC_BITS       = 20;

   // One advance step emits sixteen points
   localparam int POINTS         = 16;
   localparam int POINT_IDX_BITS = 4;

   // Action codes of an input item
   localparam logic ACT_START   = 1'b0;
   localparam logic ACT_ADVANCE = 1'b1;

   // Decision-variable constants of the Bresenham circle walk
   localparam logic signed [DEC_BITS-1:0] DEC_THREE = DEC_BITS'(3);
   localparam logic signed [DEC_BITS-1:0] DEC_SIX   = DEC_BITS'(6);
   localparam logic signed [DEC_BITS-1:0] DEC_TEN   = DEC_BITS'(10);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ROOT,
      ST_ROUND,
      ST_REPLY,
      ST_EMIT
   } ctl_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic                      capture;
      logic                      root_init;
      logic                      root_step;
      logic                      root_round;
      logic                      load_reply;
      logic                      load_point;
      logic [POINT_IDX_BITS-1:0] point_idx;
   } ctl_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic walking;
      logic root_busy;
   } dp_status_type;

endpackage

// ===== hw/rtl/antialiased_circle_rasterizer_core.sv =====
// Top level of the antialiased circle rasterizer core.
// Depends on acr_pkg, acr_ctrl, acr_datapath and the assertion macro header.
//
// Usage: an input transfer on req_* carries an action and, for a start,
// a centre and a rim point. Results leave on rsp_* one per transfer.
// A start computes the radius as the rounded square root of the squared
// centre-to-rim distance with a digit-serial root unit, one digit per
// cycle (COORD_BITS+1 digits), and then loads its one point-free result.
// An advance with steps left emits sixteen points, one per cycle while
// the output register is free; an advance with no steps left gives one
// point-free result. One item is in work at a time: req_stall stays high
// from the transfer until the last result of that item is loaded into
// the output register. The output register holds its result while
// rsp_stall is high; the block then waits and neither drops nor repeats
// a result.
// Reset (synchronous, active high) empties the output register and leaves
// the walk ended, so an advance right after reset gets a point-free reply.
`include "antialiased_circle_rasterizer_core_macros.svh"
module antialiased_circle_rasterizer_core #(
   parameter int COORD_BITS = acr_pkg::COORD_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_action,
   input  logic [acr_pkg::FIELD_BITS-1:0]       req_centre_x,
   input  logic [acr_pkg::FIELD_BITS-1:0]       req_centre_y,
   input  logic [acr_pkg::FIELD_BITS-1:0]       req_rim_x,
   input  logic [acr_pkg::FIELD_BITS-1:0]       req_rim_y,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [acr_pkg::PIX_BITS-1:0]  rsp_pixel_x,
   output logic signed [acr_pkg::PIX_BITS-1:0]  rsp_pixel_y,
   output logic                                 rsp_shade,
   output logic                                 rsp_pixel_valid,
   output logic                                 rsp_last_of_step,
   output logic                                 rsp_circle_done
);
   import acr_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   // Sequence the work of one item
   acr_ctrl #(
      .COORD_BITS (COORD_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd),
      .status     (status)
   );

   // Radius, walk and point arithmetic
   acr_datapath #(
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_centre_x     (req_centre_x),
      .req_centre_y     (req_centre_y),
      .req_rim_x        (req_rim_x),
      .req_rim_y        (req_rim_y),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_shade        (rsp_shade),
      .rsp_pixel_valid  (rsp_pixel_valid),
      .rsp_last_of_step (rsp_last_of_step),
      .rsp_circle_done  (rsp_circle_done)
   );

   // A point-free result always closes its item
   `ACR_ASSERT(a_reply_is_last, clock, reset, (rsp_valid && !rsp_pixel_valid) |-> rsp_last_of_step)
   // A dark point never closes a step
   `ACR_ASSERT_NEVER(a_dark_not_last, clock, reset, rsp_valid && rsp_pixel_valid && !rsp_shade && rsp_last_of_step)
   // Accepting an item makes the block busy on the next cycle
   `ACR_ASSERT(a_busy_after_accept, clock, reset, (req_valid && !req_stall) |=> req_stall)
   // The root unit only runs while the block is busy
   `ACR_ASSERT_NEVER(a_root_idle, clock, reset, status.root_busy && !req_stall)

endmodule

// ===== hw/rtl/acr_ctrl.sv =====
// Controller state machine of the antialiased circle rasterizer core.
// Depends on acr_pkg; drives the datapath commands and the result valid.
module acr_ctrl #(
   parameter int COORD_BITS = acr_pkg::COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_action,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output acr_pkg::ctl_cmd_type  cmd,
   input  acr_pkg::dp_status_type status
);
   import acr_pkg::*;

   localparam int CNT_BITS = $clog2(COORD_BITS + 1);

   ctl_state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]       cnt_ff, cnt_in;
   logic [POINT_IDX_BITS-1:0] pt_ff, pt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      out_free;

   // Output register can take a new result this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   // Hold state, iteration count, point index and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         pt_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pt_ff        <= pt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      pt_in          = pt_ff;
      req_stall      = 1'b1;
      cmd            = '0;
      cmd.point_idx  = pt_ff;
      // drop valid once the result is taken
      rsp_valid_in   = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_action == ACT_START) begin
                  cmd.capture = 1'b1;
                  state_in    = ST_SQUARE;
               end else if (status.walking) begin
                  pt_in    = '0;
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_REPLY;
               end
            end
         end
         ST_SQUARE: begin
            cmd.root_init = 1'b1;
            cnt_in        = '0;
            state_in      = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(COORD_BITS)) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.root_round = 1'b1;
            state_in       = ST_REPLY;
         end
         ST_REPLY: begin
            if (out_free) begin
               cmd.load_reply = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.load_point = 1'b1;
               rsp_valid_in   = 1'b1;
               pt_in          = pt_ff + 1'b1;
               if (pt_ff == POINT_IDX_BITS'(POINTS - 1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/acr_datapath.sv =====
// Datapath of the antialiased circle rasterizer core: radius root unit,
// octant walk registers, point generator and result registers. Uses acr_pkg.
module acr_datapath #(
   parameter int COORD_BITS = acr_pkg::COORD_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  acr_pkg::ctl_cmd_type                 cmd,
   output acr_pkg::dp_status_type               status,
   input  logic [acr_pkg::FIELD_BITS-1:0]       req_centre_x,
   input  logic [acr_pkg::FIELD_BITS-1:0]       req_centre_y,
   input  logic [acr_pkg::FIELD_BITS-1:0]       req_rim_x,
   input  logic [acr_pkg::FIELD_BITS-1:0]       req_rim_y,
   output logic signed [acr_pkg::PIX_BITS-1:0]  rsp_pixel_x,
   output logic signed [acr_pkg::PIX_BITS-1:0]  rsp_pixel_y,
   output logic                                 rsp_shade,
   output logic                                 rsp_pixel_valid,
   output logic                                 rsp_last_of_step,
   output logic                                 rsp_circle_done
);
   import acr_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int SQ = 2 * COORD_BITS + 2;

   // Held centre and difference vector
   logic [CB-1:0]        cx_ff, cx_in, cy_ff, cy_in;
   logic signed [CB:0]   dx_ff, dx_in, dy_ff, dy_in;
   // Root unit
   logic [SQ-1:0]        rem_ff, rem_in, res_ff, res_in, bit_ff, bit_in;
   logic signed [SQ-1:0] dx_sq, dy_sq;
   logic [SQ:0]          trial;
   logic                 trial_fits;
   logic [SQ-1:0]        res_round;
   logic [CB:0]          radius;
   logic signed [DEC_BITS-1:0] radius_dec;
   // Walk state
   logic                 walking_ff, walking_in;
   logic [CB:0]          x_ff, x_in, y_ff, y_in, x_nx, y_nx;
   logic signed [DEC_BITS-1:0] d_ff, d_in, xs, ys, d_nx;
   logic                 d_neg, walking_nx;
   // Point generator
   logic                 pt_shade, pt_last;
   logic [2:0]           pt_sel;
   logic [CB+1:0]        ly;
   logic signed [PIX_BITS-1:0] pa, pb, ox, oy, px, py;
   // Result registers
   logic signed [PIX_BITS-1:0] pix_x_ff, pix_x_in, pix_y_ff, pix_y_in;
   logic                 shade_ff, shade_in, pv_ff, pv_in, last_ff, last_in;
   logic                 done_ff, done_in;

   assign status.walking   = walking_ff;
   assign status.root_busy = (bit_ff != '0);

   // Squares of the centre-to-rim vector; the root init loads their sum
   assign dx_sq = dx_ff * dx_ff;
   assign dy_sq = dy_ff * dy_ff;

   // One root digit per cycle
   assign trial      = {1'b0, res_ff} + {1'b0, bit_ff};
   assign trial_fits = ({1'b0, rem_ff} >= trial);

   // Round to nearest: bump when the remainder exceeds the root
   assign res_round  = (rem_ff > res_ff) ? res_ff + 1'b1 : res_ff;
   assign radius     = res_round[CB:0];
   assign radius_dec = signed'(DEC_BITS'(radius));

   // Bresenham circle step update
   assign xs         = signed'(DEC_BITS'(x_ff));
   assign ys         = signed'(DEC_BITS'(y_ff));
   assign d_neg      = d_ff[DEC_BITS-1];
   assign d_nx       = d_neg ? d_ff + (xs <<< 2) + DEC_SIX
                             : d_ff + ((xs - ys) <<< 2) + DEC_TEN;
   assign x_nx       = x_ff + 1'b1;
   assign y_nx       = d_neg ? y_ff : y_ff - 1'b1;
   assign walking_nx = (x_nx < y_nx);

   // Point selection: dark point, then light neighbor, in 8-way symmetry
   assign pt_shade = cmd.point_idx[POINT_IDX_BITS-1];
   assign pt_sel   = cmd.point_idx[2:0];
   assign pt_last  = (cmd.point_idx == POINT_IDX_BITS'(POINTS - 1));
   assign ly       = d_neg ? {1'b0, y_ff} + 1'b1 : {1'b0, y_ff} - 1'b1;
   assign pa       = signed'(PIX_BITS'(x_ff));
   assign pb       = pt_shade ? signed'(PIX_BITS'(ly)) : signed'(PIX_BITS'(y_ff));

   always_comb begin
      unique case (pt_sel)
         3'd0: begin ox = pa;  oy = pb;  end
         3'd1: begin ox = pb;  oy = pa;  end
         3'd2: begin ox = pb;  oy = -pa; end
         3'd3: begin ox = pa;  oy = -pb; end
         3'd4: begin ox = -pa; oy = -pb; end
         3'd5: begin ox = -pb; oy = -pa; end
         3'd6: begin ox = -pb; oy = pa;  end
         default: begin ox = -pa; oy = pb; end
      endcase
   end

   assign px = signed'(PIX_BITS'(cx_ff)) + ox;
   assign py = signed'(PIX_BITS'(cy_ff)) + oy;

   // Next values of the datapath registers
   always_comb begin
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      rem_in     = rem_ff;
      res_in     = res_ff;
      bit_in     = bit_ff;
      walking_in = walking_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      d_in       = d_ff;
      pix_x_in   = pix_x_ff;
      pix_y_in   = pix_y_ff;
      shade_in   = shade_ff;
      pv_in      = pv_ff;
      last_in    = last_ff;
      done_in    = done_ff;

      // latch centre and difference vector on a start
      if (cmd.capture) begin
         cx_in = CB'(req_centre_x);
         cy_in = CB'(req_centre_y);
         dx_in = signed'({1'b0, CB'(req_centre_x)} - {1'b0, CB'(req_rim_x)});
         dy_in = signed'({1'b0, CB'(req_centre_y)} - {1'b0, CB'(req_rim_y)});
      end

      // load squared distance and clear the root
      if (cmd.root_init) begin
         rem_in = $unsigned(dx_sq) + $unsigned(dy_sq);
         res_in = '0;
         bit_in = SQ'(1) << (SQ - 2);
      end

      // advance the root by one digit
      if (cmd.root_step) begin
         bit_in = bit_ff >> 2;
         if (trial_fits) begin
            rem_in = rem_ff - trial[SQ-1:0];
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
      end

      // restart the octant walk from the rounded radius
      if (cmd.root_round) begin
         x_in       = '0;
         y_in       = radius;
         d_in       = DEC_THREE - (radius_dec <<< 1);
         walking_in = (radius != '0);
      end

      // point-free reply for a start or an exhausted walk
      if (cmd.load_reply) begin
         pix_x_in = '0;
         pix_y_in = '0;
         shade_in = 1'b0;
         pv_in    = 1'b0;
         last_in  = 1'b1;
         done_in  = !walking_ff;
      end

      // one plotted point; step the walk with the last one
      if (cmd.load_point) begin
         pix_x_in = px;
         pix_y_in = py;
         shade_in = pt_shade;
         pv_in    = 1'b1;
         last_in  = pt_last;
         done_in  = !walking_nx;
         if (pt_last) begin
            x_in       = x_nx;
            y_in       = y_nx;
            d_in       = d_nx;
            walking_in = walking_nx;
         end
      end
   end

   // Walk state, held centre and root bit position reset; the rest is payload
   always_ff @(posedge clock) begin
      if (reset) begin
         walking_ff <= 1'b0;
         x_ff       <= '0;
         y_ff       <= '0;
         d_ff       <= '0;
         cx_ff      <= '0;
         cy_ff      <= '0;
         bit_ff     <= '0;
      end else begin
         walking_ff <= walking_in;
         x_ff       <= x_in;
         y_ff       <= y_in;
         d_ff       <= d_in;
         cx_ff      <= cx_in;
         cy_ff      <= cy_in;
         bit_ff     <= bit_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      rem_ff   <= rem_in;
      res_ff   <= res_in;
      pix_x_ff <= pix_x_in;
      pix_y_ff <= pix_y_in;
      shade_ff <= shade_in;
      pv_ff    <= pv_in;
      last_ff  <= last_in;
      done_ff  <= done_in;
   end

   assign rsp_pixel_x      = pix_x_ff;
   assign rsp_pixel_y      = pix_y_ff;
   assign rsp_shade        = shade_ff;
   assign rsp_pixel_valid  = pv_ff;
   assign rsp_last_of_step = last_ff;
   assign rsp_circle_done  = done_ff;

endmodule
